FILE: rtl/core/rope_pkg.sv
// types and fixed-point constants shared by the rotary embedding table generator
package rope_pkg;

  localparam int ROM_DEPTH = 64;
  localparam int EXP_TERMS = 12;
  localparam int COS_TERMS = 6;
  localparam int SIN_TERMS = 5;

  localparam logic [63:0] ONE_WIDE       = 64'h1_0000_0000;
  localparam logic [63:0] MASK_Q32       = 64'hFFFF_FFFF;
  localparam logic [63:0] LOG2_THETA_Q32 = 64'd57070290109;
  localparam logic [63:0] LN2_Q32        = 64'hB172_17F8;

  localparam logic [32:0] ONE_Q32        = 33'h1_0000_0000;
  localparam logic [34:0] TWO_PI_Q32     = 35'h6_487E_D511;
  localparam logic [32:0] HALF_PI_Q32    = 33'h1_921F_B544;
  localparam logic [31:0] QUARTER_PI_Q32 = 32'hC90F_DAA2;

  localparam logic [34:0] QUARTER_TURN_1 = 35'(HALF_PI_Q32);
  localparam logic [34:0] QUARTER_TURN_2 = 35'(HALF_PI_Q32) * 35'd2;
  localparam logic [34:0] QUARTER_TURN_3 = 35'(HALF_PI_Q32) * 35'd3;
  localparam logic [34:0] QUARTER_TURN_4 = 35'(HALF_PI_Q32) * 35'd4;

  // floor(2^54 / two pi), quotient estimate for the angle reduction
  localparam logic [19:0] MOD_MAGIC = 20'((64'd1 << 54) / 64'h6_487E_D511);

  localparam logic [14:0] OUT_SCALE  = 15'd32767;
  localparam logic [47:0] ROUND_HALF = 48'h0000_8000_0000;

  // exact reciprocals ceil(2^(32+l) / d), l = ceil(log2 d), for 32-bit dividends
  localparam logic [32:0] COS_MAGIC [COS_TERMS] = '{
    33'(((65'd1 << 33) + 65'd1) / 65'd2),
    33'(((65'd1 << 36) + 65'd11) / 65'd12),
    33'(((65'd1 << 37) + 65'd29) / 65'd30),
    33'(((65'd1 << 38) + 65'd55) / 65'd56),
    33'(((65'd1 << 39) + 65'd89) / 65'd90),
    33'(((65'd1 << 40) + 65'd131) / 65'd132)
  };
  localparam int COS_SHIFT [COS_TERMS] = '{33, 36, 37, 38, 39, 40};

  localparam logic [32:0] SIN_MAGIC [SIN_TERMS] = '{
    33'(((65'd1 << 35) + 65'd5) / 65'd6),
    33'(((65'd1 << 37) + 65'd19) / 65'd20),
    33'(((65'd1 << 38) + 65'd41) / 65'd42),
    33'(((65'd1 << 39) + 65'd71) / 65'd72),
    33'(((65'd1 << 39) + 65'd109) / 65'd110)
  };
  localparam int SIN_SHIFT [SIN_TERMS] = '{35, 37, 38, 39, 39};

  typedef logic [31:0] word_arr_t [ROM_DEPTH];

  typedef struct packed {
    logic [5:0] idx;
    logic       last;
  } tag_t;

  typedef struct packed {
    tag_t       tag;
    logic [1:0] quad;
    logic       swap;
  } info_t;

endpackage

FILE: rtl/core/rotary_embedding_table_gen_core.sv
// rotary embedding table row generator: index sequencer and angle/cos/sin pipeline
// throughput: ROPE_DIM/2 results per position, one per cycle while result_stall is not raised; the next
//   position is taken while the last index of the current row issues, so rows run back to back at
//   a pace set by the single index sequencer feeding the pipeline
// reset: rst (synchronous) empties the pipeline and the sequencer and sets use_cosine to 1
module rotary_embedding_table_gen_core
  import rope_pkg::*;
#(
  parameter int ROPE_DIM      = 128,
  parameter int MAX_POSITIONS = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [12:0]        position,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [5:0]         freq_index,
  output logic signed [15:0] value,
  output logic               last
);

  localparam int ROW_LEN = ROPE_DIM / 2;
  localparam logic [5:0] LAST_IDX = 6'(ROW_LEN - 1);
  localparam logic [16:0] POS_LIMIT = 17'(MAX_POSITIONS);

  function automatic logic [31:0] inv_freq_word(int unsigned i);
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] t;
    e = (64'(2 * i) * LOG2_THETA_Q32) / 64'(ROPE_DIM);
    n = e >> 32;
    r = ((e & MASK_Q32) * LN2_Q32) >> 32;
    t = ONE_WIDE;
    for (int k = EXP_TERMS - 1; k >= 0; k--) begin
      t = ONE_WIDE - (((r * t) >> 32) / 64'(k + 1));
    end
    if (n >= 64'd40) begin
      t = '0;
    end else if (n > 64'd0) begin
      t = (t + (64'd1 << (n - 64'd1))) >> n;
    end
    if (t > MASK_Q32) begin
      t = MASK_Q32;
    end
    return t[31:0];
  endfunction

  function automatic word_arr_t build_rom();
    word_arr_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = inv_freq_word(i);
    end
    return rom;
  endfunction

  localparam word_arr_t INV_FREQ = build_rom();

  logic use_cosine;
  logic adv;
  logic accept;
  logic in_range;

  // sequencer
  logic        active;
  logic [12:0] seq_pos;
  logic [5:0]  seq_idx;
  logic        seq_last;

  // angle stages
  logic        s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic        s6_valid, s7_valid, s8_valid, s9_valid, s10_valid;
  tag_t        s1_tag, s2_tag, s3_tag, s4_tag, s5_tag;
  tag_t        s6_tag, s7_tag, s8_tag, s9_tag, s10_tag;
  logic [12:0] s1_pos, s2_pos;
  logic [31:0] s2_word;
  logic [44:0] s3_phase, s4_phase, s5_phase;
  logic [10:0] s4_qest;
  logic [44:0] s5_prod;
  logic [35:0] s6_rem;
  logic [34:0] s7_rad, s8_rad;
  logic [4:1]  s8_ge;
  logic [32:0] s9_x;
  logic [1:0]  s9_quad, s10_quad;
  logic [31:0] s10_a;
  logic        s10_swap;

  // series stages
  logic        ser_valid [0:12];
  info_t       ser_info  [0:12];
  logic [31:0] ser_a2    [0:10];
  logic [31:0] ser_a     [0:11];
  logic [31:0] cos_p     [0:COS_TERMS-1];
  logic [32:0] cos_t     [1:COS_TERMS];
  logic [31:0] sin_p     [0:SIN_TERMS-1];
  logic [32:0] sin_t     [1:SIN_TERMS];
  logic [31:0] sin_s;

  // output stages
  logic        mag_valid, sc_valid;
  tag_t        mag_tag, sc_tag;
  logic [32:0] mag_val;
  logic        mag_neg, sc_neg;
  logic [14:0] sc_mag;

  logic [51:0] mod_prod;
  logic [34:0] quad_sub;
  logic [1:0]  quad_sel;
  logic [63:0] sq_prod;
  logic [64:0] sin_prod;
  logic [47:0] scale_prod;
  logic [32:0] cx, sx, mag_pick;
  logic        neg_pick;

  assign adv        = !result_valid || !result_stall;
  assign seq_last   = (seq_idx == LAST_IDX);
  assign item_stall = !adv || (active && !seq_last);
  assign accept     = item_valid && !item_stall;
  assign in_range   = {4'b0, position} < POS_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_cosine <= 1'b1;
    end else if (cfg_we) begin
      use_cosine <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (adv) begin
      if (active && seq_last) begin
        active <= 1'b0;
      end
      if (accept) begin
        active <= in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (active) begin
        seq_idx <= seq_idx + 6'd1;
      end
      if (accept) begin
        seq_pos <= position;
        seq_idx <= '0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      s6_valid     <= 1'b0;
      s7_valid     <= 1'b0;
      s8_valid     <= 1'b0;
      s9_valid     <= 1'b0;
      s10_valid    <= 1'b0;
      for (int j = 0; j <= 12; j++) begin
        ser_valid[j] <= 1'b0;
      end
      mag_valid    <= 1'b0;
      sc_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= active;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      s6_valid     <= s5_valid;
      s7_valid     <= s6_valid;
      s8_valid     <= s7_valid;
      s9_valid     <= s8_valid;
      s10_valid    <= s9_valid;
      ser_valid[0] <= s10_valid;
      for (int j = 1; j <= 12; j++) begin
        ser_valid[j] <= ser_valid[j-1];
      end
      mag_valid    <= ser_valid[12];
      sc_valid     <= mag_valid;
      result_valid <= sc_valid;
    end
  end

  assign mod_prod = 52'(s3_phase[44:13]) * 52'(MOD_MAGIC);
  assign sq_prod  = 64'(s10_a) * 64'(s10_a);

  always_comb begin
    if (s8_ge[4]) begin
      quad_sel = 2'd0;
      quad_sub = QUARTER_TURN_4;
    end else if (s8_ge[3]) begin
      quad_sel = 2'd3;
      quad_sub = QUARTER_TURN_3;
    end else if (s8_ge[2]) begin
      quad_sel = 2'd2;
      quad_sub = QUARTER_TURN_2;
    end else if (s8_ge[1]) begin
      quad_sel = 2'd1;
      quad_sub = QUARTER_TURN_1;
    end else begin
      quad_sel = 2'd0;
      quad_sub = '0;
    end
  end

  // position times inverse frequency, reduction mod two pi, quadrant and fold
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos      <= seq_pos;
      s1_tag      <= '{idx: seq_idx, last: seq_last};

      s2_pos      <= s1_pos;
      s2_word     <= INV_FREQ[s1_tag.idx];
      s2_tag      <= s1_tag;

      s3_phase    <= 45'(s2_pos) * 45'(s2_word);
      s3_tag      <= s2_tag;

      s4_qest     <= mod_prod[51:41];
      s4_phase    <= s3_phase;
      s4_tag      <= s3_tag;

      s5_prod     <= 45'(s4_qest) * 45'(TWO_PI_Q32);
      s5_phase    <= s4_phase;
      s5_tag      <= s4_tag;

      s6_rem      <= 36'(s5_phase - s5_prod);
      s6_tag      <= s5_tag;

      if (s6_rem >= 36'(TWO_PI_Q32)) begin
        s7_rad <= 35'(s6_rem - 36'(TWO_PI_Q32));
      end else begin
        s7_rad <= s6_rem[34:0];
      end
      s7_tag      <= s6_tag;

      s8_ge[1]    <= s7_rad >= QUARTER_TURN_1;
      s8_ge[2]    <= s7_rad >= QUARTER_TURN_2;
      s8_ge[3]    <= s7_rad >= QUARTER_TURN_3;
      s8_ge[4]    <= s7_rad >= QUARTER_TURN_4;
      s8_rad      <= s7_rad;
      s8_tag      <= s7_tag;

      s9_x        <= 33'(s8_rad - quad_sub);
      s9_quad     <= quad_sel;
      s9_tag      <= s8_tag;

      if (s9_x > 33'(QUARTER_PI_Q32)) begin
        s10_a    <= 32'(HALF_PI_Q32 - s9_x);
        s10_swap <= 1'b1;
      end else begin
        s10_a    <= s9_x[31:0];
        s10_swap <= 1'b0;
      end
      s10_quad    <= s9_quad;
      s10_tag     <= s9_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ser_a2[0]   <= sq_prod[63:32];
      ser_a[0]    <= s10_a;
      ser_info[0] <= '{tag: s10_tag, quad: s10_quad, swap: s10_swap};
      for (int j = 1; j <= 10; j++) begin
        ser_a2[j] <= ser_a2[j-1];
      end
      for (int j = 1; j <= 11; j++) begin
        ser_a[j] <= ser_a[j-1];
      end
      for (int j = 1; j <= 12; j++) begin
        ser_info[j] <= ser_info[j-1];
      end
    end
  end

  // cosine series, innermost term first, two stages per term
  for (genvar m = 0; m < COS_TERMS; m++) begin : g_cos
    localparam int K = COS_TERMS - 1 - m;
    logic [64:0] mul_prod;
    logic [64:0] div_prod;
    if (m == 0) begin : g_first
      assign mul_prod = {1'b0, ser_a2[0], 32'b0};
    end else begin : g_next
      assign mul_prod = 65'(ser_a2[2*m]) * 65'(cos_t[m]);
    end
    assign div_prod = 65'(cos_p[m]) * 65'(COS_MAGIC[K]);
    always_ff @(posedge clk) begin
      if (adv) begin
        cos_p[m]   <= mul_prod[63:32];
        cos_t[m+1] <= ONE_Q32 - 33'(div_prod >> COS_SHIFT[K]);
      end
    end
  end

  // sine series, one stage behind the cosine lane
  for (genvar m = 0; m < SIN_TERMS; m++) begin : g_sin
    localparam int K = SIN_TERMS - 1 - m;
    logic [64:0] mul_prod;
    logic [64:0] div_prod;
    if (m == 0) begin : g_first
      assign mul_prod = {1'b0, ser_a2[1], 32'b0};
    end else begin : g_next
      assign mul_prod = 65'(ser_a2[2*m+1]) * 65'(sin_t[m]);
    end
    assign div_prod = 65'(sin_p[m]) * 65'(SIN_MAGIC[K]);
    always_ff @(posedge clk) begin
      if (adv) begin
        sin_p[m]   <= mul_prod[63:32];
        sin_t[m+1] <= ONE_Q32 - 33'(div_prod >> SIN_SHIFT[K]);
      end
    end
  end

  assign sin_prod = 65'(ser_a[11]) * 65'(sin_t[SIN_TERMS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_s <= sin_prod[63:32];
    end
  end

  // undo the fold and apply the quadrant sign
  always_comb begin
    cx = ser_info[12].swap ? {1'b0, sin_s} : cos_t[COS_TERMS];
    sx = ser_info[12].swap ? cos_t[COS_TERMS] : {1'b0, sin_s};
    if (use_cosine) begin
      case (ser_info[12].quad)
        2'd0:    begin mag_pick = cx; neg_pick = 1'b0; end
        2'd1:    begin mag_pick = sx; neg_pick = 1'b1; end
        2'd2:    begin mag_pick = cx; neg_pick = 1'b1; end
        default: begin mag_pick = sx; neg_pick = 1'b0; end
      endcase
    end else begin
      case (ser_info[12].quad)
        2'd0:    begin mag_pick = sx; neg_pick = 1'b0; end
        2'd1:    begin mag_pick = cx; neg_pick = 1'b0; end
        2'd2:    begin mag_pick = sx; neg_pick = 1'b1; end
        default: begin mag_pick = cx; neg_pick = 1'b1; end
      endcase
    end
  end

  assign scale_prod = 48'(mag_val) * 48'(OUT_SCALE) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_val    <= (mag_pick > ONE_Q32) ? ONE_Q32 : mag_pick;
      mag_neg    <= neg_pick;
      mag_tag    <= ser_info[12].tag;

      sc_mag     <= scale_prod[46:32];
      sc_neg     <= mag_neg;
      sc_tag     <= mag_tag;

      value      <= sc_neg ? 16'(-{1'b0, sc_mag}) : {1'b0, sc_mag};
      freq_index <= sc_tag.idx;
      last       <= sc_tag.last;
    end
  end

endmodule
